// ===== hdl/population_std_dev_engine_macros.svh =====
// Assertion helpers, clocked on clk with arst_n low masking the check.
`ifndef POPULATION_STD_DEV_ENGINE_MACROS_SVH
`define POPULATION_STD_DEV_ENGINE_MACROS_SVH

// same-cycle implication
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/psd_pkg.sv =====
package psd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MAX_SAMPLES  = 65536;

	localparam int IN_W       = 16;
	localparam int MEAN_W     = 16;
	localparam int STD_W      = 16;
	localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W      = 32;
	localparam int SQ_W       = 48;
	localparam int SQ_IN_W    = 2 * SAMPLE_WIDTH;
	localparam int MS_W       = SUM_W + MEAN_W;
	localparam int MM_W       = 2 * MEAN_W;
	localparam int NMM_W      = CNT_W + MM_W;
	localparam int D_W        = 51;
	localparam int DVD_W      = D_W - 1;
	localparam int DVS_W      = CNT_W;
	localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
	localparam int RAD_W      = 32;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = QPTR_W + 1;

	typedef struct packed {
		logic signed [IN_W-1:0] sample;
		logic                   last_sample;
	} sample_in_t;

	typedef struct packed {
		logic        [STD_W-1:0]  std_dev;
		logic signed [MEAN_W-1:0] mean_value;
		logic                     overflow;
	} result_t;

	// one finished run, handed from the accumulator to the back end
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic        [SQ_W-1:0]  sum_sq;
		logic        [CNT_W-1:0] count;
		logic                    ovf;
	} run_t;

	typedef struct packed {
		logic empty;
		logic afull;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_START,
		BK_MEAN,
		BK_MUL1,
		BK_MUL2,
		BK_DEV,
		BK_VAR,
		BK_ROOT,
		BK_DONE
	} bk_state_t;

endpackage

// ===== hdl/population_std_dev_engine.sv =====
// channel  | handshake        | payload
// samples  | push / full      | sample_item (sample, last_sample)
// results  | empty / pop      | result (std_dev, mean_value, overflow)
//
// One sample per cycle is taken while full is low; samples flow through a two-stage accumulator.
// Each run then passes through the back end: two passes of the shared divider
// (mean, then variance), then 16 square-root steps.
// A finished result holds the back end until it is popped.
// Finished runs wait in a 4-entry run queue; full rises at 3 entries.
// arst_n clears the sample, queue and divider counters, the accumulators, the back-end state and the result-valid flag.
`include "population_std_dev_engine_macros.svh"

module population_std_dev_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  psd_pkg::sample_in_t sample_item,
	output logic                empty,
	input  logic                pop,
	output psd_pkg::result_t    result
);
	import psd_pkg::*;

	logic     q_push;
	run_t     q_din;
	logic     q_pop;
	run_t     q_dout;
	q_stat_t  q_stat;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign full = q_stat.afull;

	psd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_item(sample_item),
		.run_push   (q_push),
		.run        (q_din)
	);

	psd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.dout  (q_dout),
		.stat  (q_stat)
	);

	psd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	psd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.run    (q_dout),
		.q_empty(q_stat.empty),
		.q_pop  (q_pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	`PSD_ASSERT_IMP(a_q_no_overrun, q_push, !q_stat.full, "run queue overrun")
	`PSD_ASSERT_IMP(a_q_no_underrun, q_pop, !q_stat.empty, "run queue underrun")
	`PSD_ASSERT_NXT(a_run_lands, q_push && !q_pop, !q_stat.empty, "pushed run lost")

endmodule

// ===== hdl/psd_front.sv =====
module psd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  psd_pkg::sample_in_t sample_item,
	output logic               run_push,
	output psd_pkg::run_t      run
);
	import psd_pkg::*;

	logic                           accept;
	logic signed [SAMPLE_WIDTH-1:0] xs;
	logic signed [SQ_IN_W-1:0]      sq_full;
	logic                           keep;
	logic [CNT_W-1:0]               cnt_nxt;
	logic                           ovf_nxt;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic [SQ_IN_W-1:0]             sq_s1;
	logic                           keep_s1;
	logic                           last_s1;
	logic [CNT_W-1:0]               cnt_s1;
	logic                           ovf_s1;

	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic [SUM_W-1:0] sum_nxt;
	logic [SQ_W-1:0]  sq_nxt;
	logic [SUM_W-1:0] x_ext;

	assign accept  = push && !full;
	assign xs      = sample_item.sample[SAMPLE_WIDTH-1:0];
	assign sq_full = SQ_IN_W'(xs) * SQ_IN_W'(xs);
	assign keep    = (count_q != CNT_W'(MAX_SAMPLES));
	assign cnt_nxt = keep ? count_q + CNT_W'(1) : count_q;
	assign ovf_nxt = ovf_q | !keep;

	// sample count runs at the input so the drop decision is made on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (sample_item.last_sample) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= cnt_nxt;
					ovf_q   <= ovf_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= xs;
			sq_s1   <= sq_full;
			keep_s1 <= keep;
			last_s1 <= sample_item.last_sample;
			cnt_s1  <= cnt_nxt;
			ovf_s1  <= ovf_nxt;
		end
	end

	assign x_ext   = SUM_W'(x_s1);
	assign sum_nxt = keep_s1 ? sum_q + x_ext : sum_q;
	assign sq_nxt  = keep_s1 ? sq_q + SQ_W'(sq_s1) : sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				sq_q  <= '0;
			end else begin
				sum_q <= sum_nxt;
				sq_q  <= sq_nxt;
			end
		end
	end

	assign run_push   = valid_s1 && last_s1;
	assign run.sum    = sum_nxt;
	assign run.sum_sq = sq_nxt;
	assign run.count  = cnt_s1;
	assign run.ovf    = ovf_s1;

endmodule

// ===== hdl/psd_queue.sv =====
module psd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psd_pkg::run_t    din,
	input  logic             pop,
	output psd_pkg::run_t    dout,
	output psd_pkg::q_stat_t stat
);
	import psd_pkg::*;

	run_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

	assign dout       = slot_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	// one slot kept back for a run still in the accumulator stage
	assign stat.afull = (cnt_q >= QCNT_W'(QDEPTH - 1));
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));

endmodule

// ===== hdl/psd_div.sv =====
module psd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  psd_pkg::div_req_t req,
	output psd_pkg::div_rsp_t rsp
);
	import psd_pkg::*;

	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_sub;
	logic           ge;

	// restoring, one quotient bit per cycle; quotient shifts in behind the dividend
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

// ===== hdl/psd_back.sv =====
module psd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  psd_pkg::run_t     run,
	input  logic              q_empty,
	output logic              q_pop,
	output psd_pkg::div_req_t div_req,
	input  psd_pkg::div_rsp_t div_rsp,
	output logic              empty,
	input  logic              pop,
	output psd_pkg::result_t  result
);
	import psd_pkg::*;

	bk_state_t state_q;
	bk_state_t state_nxt;

	logic signed [SUM_W-1:0]  sum_q;
	logic        [SQ_W-1:0]   sq_q;
	logic        [CNT_W-1:0]  n_q;
	logic                     ovf_q;
	logic signed [MEAN_W-1:0] m_q;
	logic signed [MS_W-1:0]   ms_q;
	logic        [MM_W-1:0]   mm_q;
	logic        [NMM_W-1:0]  nmm_q;
	logic signed [D_W-1:0]    part_q;
	logic        [RAD_W-1:0]  rad_q;
	logic        [RAD_W-1:0]  root_q;
	logic        [RAD_W-1:0]  bit_q;
	logic [ROOT_CNT_W-1:0]    step_q;
	result_t                  res_q;
	logic                     res_valid_q;

	logic        [SUM_W-1:0]  sum_mag;
	logic        [MEAN_W-1:0] mq;
	logic signed [MM_W-1:0]   mm_s;
	logic signed [D_W-1:0]    d_sum;
	logic        [DVD_W-1:0]  d_clamp;
	logic        [RAD_W-1:0]  trial;
	logic                     root_ge;
	logic                     load_res;

	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mq      = div_rsp.quot[MEAN_W-1:0];
	assign mm_s    = MM_W'(m_q) * MM_W'(m_q);
	assign d_sum   = part_q + D_W'(nmm_q);
	// exact deviation sum is never negative; clamp kept for safety
	assign d_clamp = d_sum[D_W-1] ? '0 : d_sum[DVD_W-1:0];
	assign trial   = root_q + bit_q;
	assign root_ge = (rad_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt        = state_q;
		q_pop            = 1'b0;
		load_res         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'(sum_mag);
		div_req.divisor  = n_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					state_nxt = BK_START;
				end
			end
			BK_START: begin
				div_req.start = 1'b1;
				state_nxt     = BK_MEAN;
			end
			BK_MEAN: begin
				if (div_rsp.done)
					state_nxt = BK_MUL1;
			end
			BK_MUL1: state_nxt = BK_MUL2;
			BK_MUL2: state_nxt = BK_DEV;
			BK_DEV: begin
				div_req.start    = 1'b1;
				div_req.dividend = d_clamp;
				state_nxt        = BK_VAR;
			end
			BK_VAR: begin
				if (div_rsp.done)
					state_nxt = BK_ROOT;
			end
			BK_ROOT: begin
				if (step_q == ROOT_CNT_W'(ROOT_STEPS - 1))
					state_nxt = BK_DONE;
			end
			BK_DONE: begin
				if (!res_valid_q || pop) begin
					load_res  = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				sum_q <= run.sum;
				sq_q  <= run.sum_sq;
				n_q   <= run.count;
				ovf_q <= run.ovf;
			end
			BK_MEAN: begin
				if (div_rsp.done)
					m_q <= sum_q[SUM_W-1] ? -mq : mq;
			end
			BK_MUL1: begin
				ms_q <= MS_W'(m_q) * MS_W'(sum_q);
				mm_q <= mm_s;
			end
			BK_MUL2: begin
				nmm_q  <= NMM_W'(n_q) * NMM_W'(mm_q);
				part_q <= D_W'(sq_q) - (D_W'(ms_q) << 1);
			end
			BK_VAR: begin
				rad_q  <= div_rsp.quot[RAD_W-1:0];
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
				step_q <= '0;
			end
			BK_ROOT: begin
				if (root_ge) begin
					rad_q  <= rad_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + ROOT_CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_res)
			res_valid_q <= 1'b1;
		else if (pop)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.std_dev    <= root_q[STD_W-1:0];
			res_q.mean_value <= m_q;
			res_q.overflow   <= ovf_q;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import psd_pkg::*;

	typedef struct {
		sample_in_t  item;
		int unsigned gap;
	} pending_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	sample_in_t sample_item;
	logic       empty;
	logic       pop;
	result_t    result;

	pending_t pending_q[$];
	result_t  stats_expected_q[$];

	// predicted accumulator state of the current run
	logic signed [SUM_W-1:0] acc_sum;
	logic        [SQ_W-1:0]  acc_sq;
	logic        [CNT_W-1:0] acc_count;
	logic                    acc_ovf;

	logic        in_taken;
	logic        out_taken;
	logic        nxt_push;
	logic        nxt_pop;
	int unsigned wait_cnt;
	int unsigned stall_left;
	int unsigned calm_left;
	int unsigned err_cnt;
	result_t     exp_res;
	result_t     got_res;

	population_std_dev_engine u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_item (sample_item),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// folds one sample into the run; returns 1 with the run statistics on the flagged sample
	function automatic bit fold_sample(input sample_in_t it, output result_t res);
		longint x;
		longint s;
		longint n;
		longint m;
		longint d;
		longint unsigned var_q;
		res = '0;
		x = longint'($signed(it.sample));
		if (int'(acc_count) >= MAX_SAMPLES) begin
			acc_ovf = 1'b1;
		end else begin
			acc_sum   = acc_sum + SUM_W'(x);
			acc_sq    = acc_sq + SQ_W'(x * x);
			acc_count = acc_count + 1'b1;
		end
		if (!it.last_sample)
			return 1'b0;
		s = longint'(acc_sum);
		n = longint'(acc_count);
		if (n == 0)
			n = 1;
		m = s / n;
		d = longint'(acc_sq) - 2 * m * s + n * m * m;
		if (d < 0)
			d = 0;
		var_q = longint'(d / n);
		res.std_dev    = STD_W'(floor_sqrt(var_q));
		res.mean_value = MEAN_W'(m);
		res.overflow   = acc_ovf;
		acc_sum   = '0;
		acc_sq    = '0;
		acc_count = '0;
		acc_ovf   = 1'b0;
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic queue_sample(input logic [IN_W-1:0] v, input bit last, input int unsigned gap);
		pending_t p;
		p.item.sample      = v;
		p.item.last_sample = last;
		p.gap              = gap;
		pending_q.push_back(p);
	endtask

	function automatic logic [IN_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 15);
		case (r)
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7fff;
			end
			2: begin
				return 16'h0000;
			end
			3: begin
				return 16'hffff;
			end
			4, 5: begin
				return IN_W'($signed($urandom_range(0, 16)) - 8);
			end
			default: begin
				return IN_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// input and output monitor
	always @(posedge clk) begin
		in_taken  <= arst_n && push && !full;
		out_taken <= arst_n && pop && !empty;
		if (arst_n) begin
			if (push && !full) begin
				if (fold_sample(sample_item, exp_res))
					stats_expected_q.push_back(exp_res);
			end
			if (pop && !empty) begin
				got_res = result;
				if (stats_expected_q.size() == 0) begin
					flag_error($sformatf("result with nothing expected: std_dev %0d mean %0d ovf %0b",
						got_res.std_dev, got_res.mean_value, got_res.overflow));
				end else begin
					exp_res = stats_expected_q.pop_front();
					if (got_res.std_dev !== exp_res.std_dev)
						flag_error($sformatf("std_dev got %0d exp %0d",
							got_res.std_dev, exp_res.std_dev));
					if (got_res.mean_value !== exp_res.mean_value)
						flag_error($sformatf("mean_value got %0d exp %0d",
							got_res.mean_value, exp_res.mean_value));
					if (got_res.overflow !== exp_res.overflow)
						flag_error($sformatf("overflow got %0b exp %0b",
							got_res.overflow, exp_res.overflow));
				end
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (arst_n) begin
			nxt_push = push;
			if (push && in_taken)
				nxt_push = 1'b0;
			if (!nxt_push && pending_q.size() > 0) begin
				if (wait_cnt >= pending_q[0].gap) begin
					sample_item <= pending_q[0].item;
					pending_q.pop_front();
					nxt_push = 1'b1;
					wait_cnt = 0;
				end else begin
					wait_cnt++;
				end
			end
			push <= nxt_push;
		end
	end

	// result reader, stalls drawn per transfer with occasional calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			nxt_pop = pop;
			if (pop && out_taken) begin
				nxt_pop = 1'b0;
				if (calm_left > 0) begin
					calm_left--;
					stall_left = 0;
				end else begin
					if ($urandom_range(0, 9) == 0)
						calm_left = 25;
					stall_left = $urandom_range(0, 18);
				end
			end
			if (!nxt_pop) begin
				if (stall_left == 0)
					nxt_pop = 1'b1;
				else
					stall_left--;
			end
			pop <= nxt_pop;
		end
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned items;
		int unsigned run_len;
		int unsigned r;
		bit quiet;
		bit flat;
		logic [IN_W-1:0] base;
		logic [IN_W-1:0] v;

		clk         = 1'b0;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		sample_item = '0;
		in_taken    = 1'b0;
		out_taken   = 1'b0;
		wait_cnt    = 0;
		stall_left  = 0;
		calm_left   = 0;
		err_cnt     = 0;
		acc_sum     = '0;
		acc_sq      = '0;
		acc_count   = '0;
		acc_ovf     = 1'b0;

		// single-sample runs at the extremes
		queue_sample(16'h7fff, 1'b1, $urandom_range(0, 18));
		queue_sample(16'h8000, 1'b1, $urandom_range(0, 18));
		queue_sample(16'h0000, 1'b1, $urandom_range(0, 18));
		// mean truncates toward zero on both signs
		queue_sample(16'h8000, 1'b0, $urandom_range(0, 18));
		queue_sample(16'h7fff, 1'b1, $urandom_range(0, 18));
		queue_sample(16'hffff, 1'b0, $urandom_range(0, 18));
		queue_sample(16'hfffe, 1'b1, $urandom_range(0, 18));
		queue_sample(16'h0001, 1'b0, $urandom_range(0, 18));
		queue_sample(16'h0002, 1'b1, $urandom_range(0, 18));
		// widest spread
		queue_sample(16'h7fff, 1'b0, 0);
		queue_sample(16'h8000, 1'b0, 0);
		queue_sample(16'h7fff, 1'b0, 0);
		queue_sample(16'h8000, 1'b1, 0);
		queue_sample(16'h0005, 1'b0, $urandom_range(0, 18));
		queue_sample(16'h0005, 1'b0, $urandom_range(0, 18));
		queue_sample(16'h0005, 1'b1, $urandom_range(0, 18));
		queue_sample(16'h0003, 1'b1, $urandom_range(0, 18));

		items = 0;
		while (items < 2000) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				run_len = $urandom_range(1, 8);
			else if (r < 9)
				run_len = $urandom_range(9, 40);
			else
				run_len = $urandom_range(41, 200);
			quiet = ($urandom_range(0, 2) == 0);
			flat  = ($urandom_range(0, 9) == 0);
			base  = pick_value();
			for (int k = 0; k < run_len; k++) begin
				v = flat ? base : pick_value();
				queue_sample(v, k == run_len - 1, quiet ? 0 : $urandom_range(0, 18));
			end
			items += run_len;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0 && !push);
		wait (stats_expected_q.size() == 0);
		repeat (400) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== population_std_dev_engine.f =====
+incdir+hdl
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_queue.sv
hdl/psd_div.sv
hdl/psd_back.sv
hdl/population_std_dev_engine.sv
dv/tb.sv
